[rtl/eav_pkg.sv]
// ----------------------------------------------------------------------------
// eav_pkg
// Shared types and constants of the endpoint address validator.
// ----------------------------------------------------------------------------
package eav_pkg;

	localparam int MAX_NAME_LENGTH_DEF    = 253;
	localparam int MAX_LABEL_LENGTH_DEF   = 63;
	localparam int MAX_IP_TEXT_LENGTH_DEF = 63;
	localparam int QUEUE_DEPTH            = 2;

	localparam logic [16:0] PORT_MAX        = 17'd65535;
	localparam logic [2:0]  PORT_DIGITS_MAX = 3'd5;
	localparam logic [3:0]  IPV6_UNITS      = 4'd8;
	localparam logic [2:0]  HEX_DIGITS_MAX  = 3'd4;

	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_TILDE   = 8'h7E;
	localparam logic [7:0] CH_TWO     = 8'h32;
	localparam logic [7:0] CH_FIVE    = 8'h35;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} eav_in_t;

	typedef struct packed {
		logic        valid_res;
		logic        bracketed;
		logic        port_present;
		logic [15:0] port_number;
		logic        prefix_present;
		logic [7:0]  host_length;
	} eav_out_t;

	typedef struct packed {
		logic       is_digit;
		logic       is_hex;
		logic       is_alnum;
		logic       is_prefix;
		logic       colon;
		logic       slash;
		logic       dot;
		logic       dash;
		logic       lbrack;
		logic       rbrack;
		logic       percent;
		logic       two;
		logic       five;
		logic [3:0] digit;
		logic       last;
	} eav_item_t;

endpackage

[rtl/eav_front.sv]
// ----------------------------------------------------------------------------
// eav_front
// Classifies each incoming character into the flags the parser needs.
// ----------------------------------------------------------------------------
module eav_front (
	input  eav_pkg::eav_in_t   data,
	output eav_pkg::eav_item_t item
);

	logic [7:0] c;
	logic       dig;
	logic       upper;
	logic       lower;

	assign c     = data.character;
	assign dig   = (c >= 8'h30) && (c <= 8'h39);
	assign upper = (c >= 8'h41) && (c <= 8'h5A);
	assign lower = (c >= 8'h61) && (c <= 8'h7A);

	always_comb begin
		item           = '0;
		item.is_digit  = dig;
		item.is_hex    = dig || ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
		item.is_alnum  = dig || upper || lower;
		item.is_prefix = dig || upper || lower || (c == eav_pkg::CH_DOT) ||
			(c == eav_pkg::CH_UNDER) || (c == eav_pkg::CH_TILDE) || (c == eav_pkg::CH_DASH);
		item.colon     = (c == eav_pkg::CH_COLON);
		item.slash     = (c == eav_pkg::CH_SLASH);
		item.dot       = (c == eav_pkg::CH_DOT);
		item.dash      = (c == eav_pkg::CH_DASH);
		item.lbrack    = (c == eav_pkg::CH_LBRACK);
		item.rbrack    = (c == eav_pkg::CH_RBRACK);
		item.percent   = (c == eav_pkg::CH_PERCENT);
		item.two       = (c == eav_pkg::CH_TWO);
		item.five      = (c == eav_pkg::CH_FIVE);
		item.digit     = c[3:0];
		item.last      = data.last;
	end

endmodule

[rtl/eav_queue.sv]
// ----------------------------------------------------------------------------
// eav_queue
// Short queue of classified characters between the front and the parser.
// ----------------------------------------------------------------------------
module eav_queue #(
	parameter int DEPTH = eav_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  eav_pkg::eav_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               nonempty,
	output eav_pkg::eav_item_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	eav_pkg::eav_item_t entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = entries_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/eav_core.sv]
// ----------------------------------------------------------------------------
// eav_core
// Parser state machine that walks the classified characters and registers
// one verdict at the end of each string.
// ----------------------------------------------------------------------------
module eav_core #(
	parameter int MAX_NAME_LENGTH    = eav_pkg::MAX_NAME_LENGTH_DEF,
	parameter int MAX_LABEL_LENGTH   = eav_pkg::MAX_LABEL_LENGTH_DEF,
	parameter int MAX_IP_TEXT_LENGTH = eav_pkg::MAX_IP_TEXT_LENGTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  eav_pkg::eav_item_t item,
	output logic               item_pop,
	output logic               verdict_valid,
	input  logic               verdict_ready,
	output eav_pkg::eav_out_t  verdict_data
);

	localparam int LW = $clog2(MAX_LABEL_LENGTH + 1);

	typedef enum logic [2:0] {
		PH_START,
		PH_DNS,
		PH_IPV6,
		PH_AFTER,
		PH_PORT,
		PH_PREFIX
	} phase_t;

	phase_t        phase_q,  phase_n;
	logic          failed_q, failed_n;
	logic [8:0]    hc_q,     hc_n;
	logic [LW-1:0] lc_q,     lc_n;
	logic          pdash_q,  pdash_n;
	logic [16:0]   pacc_q,   pacc_n;
	logic [2:0]    pdc_q,    pdc_n;
	logic [3:0]    gc_q,     gc_n;
	logic [2:0]    dc_q,     dc_n;
	logic          cs_q,     cs_n;
	logic [2:0]    tail_q,   tail_n;
	logic [2:0]    zone_q,   zone_n;
	logic [1:0]    crun_q,   crun_n;
	logic [13:0]   fv_q,     fv_n;
	logic          fdec_q,   fdec_n;
	logic [9:0]    ov_q,     ov_n;
	logic [1:0]    od_q,     od_n;
	logic          sbr_q,    sbr_n;
	logic          spt_q,    spt_n;
	logic          spf_q,    spf_n;
	eav_pkg::eav_out_t res;

	assign item_pop = item_valid && !(item.last && verdict_valid && !verdict_ready);

	always_comb begin
		logic       dns_end;
		logic       host_ch;
		logic       ok;
		logic [4:0] gsum;
		dns_end  = 1'b0;
		host_ch  = 1'b0;
		ok       = 1'b0;
		phase_n  = phase_q;
		failed_n = failed_q;
		hc_n     = hc_q;
		lc_n     = lc_q;
		pdash_n  = pdash_q;
		pacc_n   = pacc_q;
		pdc_n    = pdc_q;
		gc_n     = gc_q;
		dc_n     = dc_q;
		cs_n     = cs_q;
		tail_n   = tail_q;
		zone_n   = zone_q;
		crun_n   = crun_q;
		fv_n     = fv_q;
		fdec_n   = fdec_q;
		ov_n     = ov_q;
		od_n     = od_q;
		sbr_n    = sbr_q;
		spt_n    = spt_q;
		spf_n    = spf_q;
		res      = '0;
		gsum     = '0;

		case (phase_q)
			PH_START: begin
				if (item.lbrack) begin
					sbr_n   = 1'b1;
					phase_n = PH_IPV6;
				end else begin
					phase_n = PH_DNS;
					host_ch = 1'b1;
				end
			end
			PH_DNS: host_ch = 1'b1;
			PH_IPV6: begin
				if (zone_q == 3'd0 && (item.rbrack || item.percent)) begin
					if (hc_q == 9'd0 || hc_q > 9'(MAX_IP_TEXT_LENGTH)) failed_n = 1'b1;
					gsum = {1'b0, gc_q};
					if (tail_q != 3'd0) begin
						if (tail_q != 3'd4 || od_q == 2'd0) failed_n = 1'b1;
						else gsum = gsum + 5'd2;
					end else if (dc_q != 3'd0) begin
						gsum = gsum + 5'd1;
					end else if (crun_q != 2'd2) begin
						failed_n = 1'b1;
					end
					if (gsum > {1'b0, eav_pkg::IPV6_UNITS}) failed_n = 1'b1;
					else gc_n = gsum[3:0];
					if (cs_q ? (gc_n > 4'd7) : (gc_n != eav_pkg::IPV6_UNITS)) failed_n = 1'b1;
				end
				if (item.rbrack) begin
					if (zone_q != 3'd0 && zone_q < 3'd4) failed_n = 1'b1;
					phase_n = PH_AFTER;
				end else begin
					if (zone_q == 3'd0) begin
						if (item.percent) begin
							zone_n = 3'd1;
						end else if (item.colon) begin
							if (tail_q != 3'd0) begin
								failed_n = 1'b1;
							end else if (dc_q != 3'd0) begin
								if (gc_q + 4'd1 > eav_pkg::IPV6_UNITS) failed_n = 1'b1;
								else gc_n = gc_q + 4'd1;
								dc_n   = '0;
								fv_n   = '0;
								fdec_n = 1'b1;
								crun_n = 2'd1;
							end else if (crun_q == 2'd1) begin
								if (cs_q) failed_n = 1'b1;
								cs_n   = 1'b1;
								crun_n = 2'd2;
							end else if (crun_q == 2'd2) begin
								failed_n = 1'b1;
							end else begin
								crun_n = 2'd1;
							end
						end else begin
							if (crun_q == 2'd1 && hc_q == 9'd1) failed_n = 1'b1;
							crun_n = 2'd0;
							if (tail_q != 3'd0) begin
								if (item.is_digit) begin
									if (od_q == 2'd3) begin
										failed_n = 1'b1;
									end else begin
										ov_n = 10'((ov_q << 3) + (ov_q << 1)) + 10'(item.digit);
										od_n = od_q + 2'd1;
										if (ov_n > 10'd255) failed_n = 1'b1;
									end
								end else if (item.dot) begin
									if (od_q == 2'd0 || tail_q >= 3'd4) begin
										failed_n = 1'b1;
									end else begin
										tail_n = tail_q + 3'd1;
										ov_n   = '0;
										od_n   = '0;
									end
								end else begin
									failed_n = 1'b1;
								end
							end else if (item.dot) begin
								if (dc_q == 3'd0 || dc_q > 3'd3 || !fdec_q || fv_q > 14'd255) begin
									failed_n = 1'b1;
								end else begin
									tail_n = 3'd2;
									ov_n   = '0;
									od_n   = '0;
								end
							end else if (item.is_hex) begin
								if (dc_q >= eav_pkg::HEX_DIGITS_MAX) begin
									failed_n = 1'b1;
								end else begin
									dc_n = dc_q + 3'd1;
									if (item.is_digit) begin
										fv_n = 14'((fv_q << 3) + (fv_q << 1)) + 14'(item.digit);
									end else begin
										fdec_n = 1'b0;
									end
								end
							end else begin
								failed_n = 1'b1;
							end
						end
					end else if (zone_q == 3'd1) begin
						if (item.two) zone_n = 3'd2;
						else failed_n = 1'b1;
					end else if (zone_q == 3'd2) begin
						if (item.five) zone_n = 3'd3;
						else failed_n = 1'b1;
					end else begin
						if (item.is_prefix) zone_n = 3'd4;
						else failed_n = 1'b1;
					end
					if (hc_q != 9'd256) hc_n = hc_q + 9'd1;
				end
			end
			PH_AFTER: begin
				if (item.colon) begin
					phase_n = PH_PORT;
					spt_n   = 1'b1;
				end else if (item.slash) begin
					phase_n = PH_PREFIX;
					spf_n   = 1'b1;
				end else begin
					failed_n = 1'b1;
				end
			end
			PH_PORT: begin
				if (item.is_digit) begin
					if (pdc_q >= eav_pkg::PORT_DIGITS_MAX) begin
						failed_n = 1'b1;
					end else begin
						pacc_n = 17'((pacc_q << 3) + (pacc_q << 1)) + 17'(item.digit);
						pdc_n  = pdc_q + 3'd1;
					end
				end else if (item.slash) begin
					if (pdc_q == 3'd0 || pacc_q == 17'd0 || pacc_q > eav_pkg::PORT_MAX) begin
						failed_n = 1'b1;
					end
					phase_n = PH_PREFIX;
					spf_n   = 1'b1;
				end else begin
					failed_n = 1'b1;
				end
			end
			PH_PREFIX: begin
				if (!item.is_prefix && !item.slash) failed_n = 1'b1;
			end
			default: failed_n = 1'b1;
		endcase

		if (host_ch) begin
			if (item.colon) begin
				dns_end = 1'b1;
				phase_n = PH_PORT;
				spt_n   = 1'b1;
			end else if (item.slash) begin
				dns_end = 1'b1;
				phase_n = PH_PREFIX;
				spf_n   = 1'b1;
			end else begin
				if (item.dot) begin
					if (lc_q == '0 || pdash_q) failed_n = 1'b1;
					lc_n = '0;
				end else if (item.is_alnum || item.dash) begin
					if (lc_q == '0 && item.dash) failed_n = 1'b1;
					if (lc_q >= LW'(MAX_LABEL_LENGTH)) failed_n = 1'b1;
					else lc_n = lc_q + 1'b1;
				end else begin
					failed_n = 1'b1;
				end
				pdash_n = item.dash;
				if (hc_q != 9'd256) hc_n = hc_q + 9'd1;
			end
		end

		if (item.last && phase_n == PH_DNS) dns_end = 1'b1;
		if (dns_end) begin
			if (hc_n == 9'd0 || hc_n > 9'(MAX_NAME_LENGTH) || lc_n == '0 || pdash_n) begin
				failed_n = 1'b1;
			end
		end

		if (item.last) begin
			if (phase_n == PH_IPV6 || phase_n == PH_START) begin
				failed_n = 1'b1;
			end else if (phase_n == PH_PORT) begin
				if (pdc_n == 3'd0 || pacc_n == 17'd0 || pacc_n > eav_pkg::PORT_MAX) begin
					failed_n = 1'b1;
				end
			end
			ok                 = !failed_n;
			res.valid_res      = ok;
			res.bracketed      = ok && sbr_n;
			res.port_present   = ok && spt_n;
			res.port_number    = (ok && spt_n) ? pacc_n[15:0] : 16'd0;
			res.prefix_present = ok && spf_n;
			res.host_length    = ok ? (hc_n[8] ? 8'd255 : hc_n[7:0]) : 8'd0;
			phase_n  = PH_START;
			failed_n = 1'b0;
			hc_n     = '0;
			lc_n     = '0;
			pdash_n  = 1'b0;
			pacc_n   = '0;
			pdc_n    = '0;
			gc_n     = '0;
			dc_n     = '0;
			cs_n     = 1'b0;
			tail_n   = '0;
			zone_n   = '0;
			crun_n   = '0;
			fv_n     = '0;
			fdec_n   = 1'b1;
			ov_n     = '0;
			od_n     = '0;
			sbr_n    = 1'b0;
			spt_n    = 1'b0;
			spf_n    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_START;
			failed_q      <= 1'b0;
			hc_q          <= '0;
			lc_q          <= '0;
			pdash_q       <= 1'b0;
			pacc_q        <= '0;
			pdc_q         <= '0;
			gc_q          <= '0;
			dc_q          <= '0;
			cs_q          <= 1'b0;
			tail_q        <= '0;
			zone_q        <= '0;
			crun_q        <= '0;
			fv_q          <= '0;
			fdec_q        <= 1'b1;
			ov_q          <= '0;
			od_q          <= '0;
			sbr_q         <= 1'b0;
			spt_q         <= 1'b0;
			spf_q         <= 1'b0;
			verdict_valid <= 1'b0;
		end else begin
			if (item_pop) begin
				phase_q  <= phase_n;
				failed_q <= failed_n;
				hc_q     <= hc_n;
				lc_q     <= lc_n;
				pdash_q  <= pdash_n;
				pacc_q   <= pacc_n;
				pdc_q    <= pdc_n;
				gc_q     <= gc_n;
				dc_q     <= dc_n;
				cs_q     <= cs_n;
				tail_q   <= tail_n;
				zone_q   <= zone_n;
				crun_q   <= crun_n;
				fv_q     <= fv_n;
				fdec_q   <= fdec_n;
				ov_q     <= ov_n;
				od_q     <= od_n;
				sbr_q    <= sbr_n;
				spt_q    <= spt_n;
				spf_q    <= spf_n;
			end
			if (item_pop && item.last) begin
				verdict_valid <= 1'b1;
			end else if (verdict_ready) begin
				verdict_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop && item.last) begin
			verdict_data <= res;
		end
	end

endmodule

[rtl/endpoint_address_validator.sv]
// ----------------------------------------------------------------------------
// endpoint_address_validator
// Checks host[:port][/prefix] endpoint strings streamed one character a beat.
// ----------------------------------------------------------------------------
// Characters enter on the char channel (valid/ready), one beat each, with last
// set on the final character of a string. The front classifies each beat and
// writes it into a two-entry queue; the parser pops one beat per cycle when not
// held. One verdict beat per string leaves on the verdict channel, registered
// in the parser as it pops the string's last character. Sustained throughput
// is one character per cycle while verdicts are taken.
// A verdict that is not taken holds the parser only when the next string's
// last character reaches it; other characters keep flowing, and the queue
// fills before char_ready drops.
// Reset clears the queue, the parser state and the verdict valid flag, so the
// block starts at the beginning of a new string.
// ----------------------------------------------------------------------------
module endpoint_address_validator #(
	parameter int MAX_NAME_LENGTH    = eav_pkg::MAX_NAME_LENGTH_DEF,
	parameter int MAX_LABEL_LENGTH   = eav_pkg::MAX_LABEL_LENGTH_DEF,
	parameter int MAX_IP_TEXT_LENGTH = eav_pkg::MAX_IP_TEXT_LENGTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_ready,
	input  eav_pkg::eav_in_t  char_data,
	output logic              verdict_valid,
	input  logic              verdict_ready,
	output eav_pkg::eav_out_t verdict_data
);

	eav_pkg::eav_item_t front_item;
	eav_pkg::eav_item_t head_item;
	logic               q_full;
	logic               q_nonempty;
	logic               q_pop;

	eav_front u_front (
		.data (char_data),
		.item (front_item)
	);

	eav_queue #(
		.DEPTH (eav_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (char_valid),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.head      (head_item)
	);

	assign char_ready = !q_full;

	eav_core #(
		.MAX_NAME_LENGTH    (MAX_NAME_LENGTH),
		.MAX_LABEL_LENGTH   (MAX_LABEL_LENGTH),
		.MAX_IP_TEXT_LENGTH (MAX_IP_TEXT_LENGTH)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (q_nonempty),
		.item          (head_item),
		.item_pop      (q_pop),
		.verdict_valid (verdict_valid),
		.verdict_ready (verdict_ready),
		.verdict_data  (verdict_data)
	);

`ifndef SYNTHESIS
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && !verdict_data.valid_res |->
		verdict_data.port_number == 16'd0 && verdict_data.host_length == 8'd0 &&
		!verdict_data.bracketed && !verdict_data.port_present &&
		!verdict_data.prefix_present)
		else $error("failed verdict carries nonzero fields");
	a_port_zero: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && !verdict_data.port_present |-> verdict_data.port_number == 16'd0)
		else $error("port number without port");
	a_host_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && verdict_data.valid_res |-> verdict_data.host_length != 8'd0)
		else $error("valid verdict with empty host");
`endif

endmodule
